@@ rtl/rational_arithmetic_unit_defines.svh @@
// assertion macros for the rational arithmetic unit
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau check failed");
// next-cycle implication checked outside reset
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rau check failed");
`endif

@@ rtl/rau_pkg.sv @@
// shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
  localparam int OperandWidth = 16;
  localparam int ProdWidth = 2 * OperandWidth;
  localparam int SumWidth = ProdWidth + 1;
  localparam int NumWidth = 33;
  localparam int DenWidth = 32;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                       err;
    logic                       zero;
    logic                       num_neg;
    logic                       den_neg;
    logic [SumWidth-1:0]        num_mag;
    logic [SumWidth-1:0]        den_mag;
  } work_t;
endpackage

@@ rtl/rau_front.sv @@
// front end: operand check and cross products, two registered steps
// depends on rau_pkg
module rau_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          req_type,
  input  logic signed [rau_pkg::OperandWidth-1:0] first_numerator,
  input  logic signed [rau_pkg::OperandWidth-1:0] first_denominator,
  input  logic signed [rau_pkg::OperandWidth-1:0] second_numerator,
  input  logic signed [rau_pkg::OperandWidth-1:0] second_denominator,
  output logic                                wvalid,
  input  logic                                wready,
  output rau_pkg::work_t                      wdata
);
  logic                                  s1_valid;
  logic                                  s1_err;
  logic [1:0]                            s1_op;
  logic signed [rau_pkg::ProdWidth-1:0]  p_ad;
  logic signed [rau_pkg::ProdWidth-1:0]  p_cb;
  logic signed [rau_pkg::ProdWidth-1:0]  p_ac;
  logic signed [rau_pkg::ProdWidth-1:0]  p_bd;
  logic signed [rau_pkg::SumWidth-1:0]   num;
  logic signed [rau_pkg::SumWidth-1:0]   den;
  logic                                  s1_take;

  assign full = s1_valid && !s1_take;
  assign s1_take = !wvalid || wready;

  // stage one: products and error check
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (push && !full) begin
        s1_valid <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
    if (push && !full) begin
      s1_op <= req_type;
      s1_err <= (first_denominator == '0) || (second_denominator == '0) ||
                (req_type == rau_pkg::OP_DIV && second_numerator == '0);
      p_ad <= first_numerator * second_denominator;
      p_cb <= second_numerator * first_denominator;
      p_ac <= first_numerator * second_numerator;
      p_bd <= first_denominator * second_denominator;
    end
  end

  // combine products per opcode
  always_comb begin
    unique case (rau_pkg::op_t'(s1_op))
      rau_pkg::OP_ADD: begin
        num = rau_pkg::SumWidth'(p_ad) + rau_pkg::SumWidth'(p_cb);
        den = rau_pkg::SumWidth'(p_bd);
      end
      rau_pkg::OP_SUB: begin
        num = rau_pkg::SumWidth'(p_ad) - rau_pkg::SumWidth'(p_cb);
        den = rau_pkg::SumWidth'(p_bd);
      end
      rau_pkg::OP_MUL: begin
        num = rau_pkg::SumWidth'(p_ac);
        den = rau_pkg::SumWidth'(p_bd);
      end
      default: begin
        num = rau_pkg::SumWidth'(p_ad);
        den = rau_pkg::SumWidth'(p_cb);
      end
    endcase
  end

  // stage two: signs and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
    end else if (s1_take) begin
      wvalid <= s1_valid;
    end
    if (s1_take) begin
      wdata.err <= s1_err;
      wdata.zero <= (num == '0);
      wdata.num_neg <= num[rau_pkg::SumWidth-1];
      wdata.den_neg <= den[rau_pkg::SumWidth-1];
      wdata.num_mag <= num[rau_pkg::SumWidth-1] ? -num : num;
      wdata.den_mag <= den[rau_pkg::SumWidth-1] ? -den : den;
    end
  end
endmodule

@@ rtl/rau_queue.sv @@
// short request queue between front and back ends
// depends on rau_pkg
module rau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rau_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rau_pkg::work_t out_data
);
  localparam int PtrW = $clog2(rau_pkg::QueueDepth);
  rau_pkg::work_t        mem [rau_pkg::QueueDepth];
  logic [PtrW-1:0]       wptr;
  logic [PtrW-1:0]       rptr;
  logic [PtrW:0]         count;
  logic                  wr;
  logic                  rd;

  assign in_ready = count != PtrW'(0) + (PtrW+1)'(rau_pkg::QueueDepth);
  assign out_valid = count != '0;
  assign out_data = mem[rptr];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  // pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
    if (wr) begin
      mem[wptr] <= in_data;
    end
  end
endmodule

@@ rtl/rau_back.sv @@
// back end: binary gcd then two restoring divisions, one bit a cycle
// depends on rau_pkg
module rau_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wvalid,
  output logic                                   wready,
  input  rau_pkg::work_t                         wdata,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [rau_pkg::NumWidth-1:0]    result_numerator,
  output logic signed [rau_pkg::DenWidth-1:0]    result_denominator,
  output logic                                   error
);
  localparam int W = rau_pkg::SumWidth;
  localparam int CntW = $clog2(W + 1);

  typedef enum logic [2:0] {S_IDLE, S_GCD, S_SHIFT, S_DIVN, S_DIVD, S_DONE} state_t;

  state_t          state;
  rau_pkg::work_t  job;
  logic [W-1:0]    u;
  logic [W-1:0]    v;
  logic [CntW-1:0] k;
  logic [W-1:0]    g;
  logic [W-1:0]    rem;
  logic [W-1:0]    quo;
  logic [CntW-1:0] cnt;
  logic [W-1:0]    qn;
  logic [W:0]      trial;
  logic [W-1:0]    dividend;

  assign wready = (state == S_IDLE);
  assign dividend = (state == S_DIVN) ? job.num_mag : job.den_mag;
  assign trial = {rem, dividend[cnt - 1'b1]} - {1'b0, g};

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (wvalid) begin
            job <= wdata;
            u <= wdata.num_mag;
            v <= wdata.den_mag;
            k <= '0;
            state <= (wdata.err || wdata.zero) ? S_DONE : S_GCD;
          end
        end
        S_GCD: begin
          // binary gcd: strip common twos and single twos, then subtract
          if (u == v) begin
            g <= u;
            state <= S_SHIFT;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        S_SHIFT: begin
          g <= g << k;
          rem <= '0;
          cnt <= CntW'(W);
          state <= S_DIVN;
        end
        S_DIVN, S_DIVD: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= {rem[W-2:0], dividend[cnt - 1'b1]};
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            if (state == S_DIVN) begin
              qn <= {quo[W-2:0], !trial[W]};
              rem <= '0;
              cnt <= CntW'(W);
              state <= S_DIVD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (empty || pop) begin
            empty <= 1'b0;
            error <= job.err;
            if (job.err) begin
              result_numerator <= '0;
              result_denominator <= '0;
            end else if (job.zero) begin
              result_numerator <= '0;
              result_denominator <= rau_pkg::DenWidth'(1);
            end else begin
              result_numerator <= job.num_neg ? -qn : qn;
              result_denominator <= rau_pkg::DenWidth'(job.den_neg ? -quo : quo);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (pop && !empty && !(state == S_DONE)) begin
        empty <= 1'b1;
      end
    end
  end
endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// rational arithmetic unit: a request passes the two front-end stages and the queue before
// the back end; an error or zero-numerator request goes straight to the result register, any
// other passes through the binary gcd loop and two 33-step restoring divisions; the back end
// works on one request at a time while the front end and a two-entry queue keep taking
// requests meanwhile
// synchronous active-high reset empties front, queue and result register.
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      push,
  output logic                                      full,
  input  logic [1:0]                                req_type,
  input  logic signed [rau_pkg::OperandWidth-1:0]   first_numerator,
  input  logic signed [rau_pkg::OperandWidth-1:0]   first_denominator,
  input  logic signed [rau_pkg::OperandWidth-1:0]   second_numerator,
  input  logic signed [rau_pkg::OperandWidth-1:0]   second_denominator,
  output logic                                      empty,
  input  logic                                      pop,
  output logic signed [rau_pkg::NumWidth-1:0]       result_numerator,
  output logic signed [rau_pkg::DenWidth-1:0]       result_denominator,
  output logic                                      error
);
  logic           f_valid;
  logic           f_ready;
  rau_pkg::work_t f_data;
  logic           q_valid;
  logic           q_ready;
  rau_pkg::work_t q_data;

  // front end
  rau_front u_front (
    .clk, .rst, .push, .full, .req_type, .first_numerator, .first_denominator,
    .second_numerator, .second_denominator,
    .wvalid(f_valid), .wready(f_ready), .wdata(f_data)
  );

  // decoupling queue
  rau_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  // back end
  rau_back u_back (
    .clk, .rst, .wvalid(q_valid), .wready(q_ready), .wdata(q_data),
    .empty, .pop, .result_numerator, .result_denominator, .error
  );

  `RAU_ASSERT_IMP(a_err_zero, clk, rst, !empty && error, result_denominator == '0)
  `RAU_ASSERT_IMP(a_num_zero, clk, rst, !empty && !error && result_numerator == '0,
    result_denominator == 1)
  `RAU_ASSERT_NXT(a_hold, clk, rst, !empty && !pop, !empty)
endmodule

@@ bench/rational_arithmetic_unit_tb.sv @@
// self-checking bench for the rational arithmetic unit: directed table, then random requests
// depends on rau_pkg and the rational_arithmetic_unit rtl
module rational_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;
  localparam int RandomCount = 1950;
  localparam int OpW = rau_pkg::OperandWidth;

  typedef struct {
    logic [rau_pkg::NumWidth-1:0] num;
    logic [rau_pkg::DenWidth-1:0] den;
    logic                         err;
  } fraction_t;

  typedef struct {
    rau_pkg::op_t      op;
    logic [OpW-1:0]    a, b, c, d;
    bit                typed;
    fraction_t         want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] req_type = '0;
  logic signed [OpW-1:0] first_numerator = '0, first_denominator = '0;
  logic signed [OpW-1:0] second_numerator = '0, second_denominator = '0;
  logic signed [rau_pkg::NumWidth-1:0] result_numerator;
  logic signed [rau_pkg::DenWidth-1:0] result_denominator;
  logic error;

  fraction_t expected_q[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 28;
  int  recv_idle_pct = 84;
  int  hold_cycles = 0;

  rational_arithmetic_unit dut (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint unsigned common_divisor(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduced fraction for one request
  function automatic fraction_t reduce_fraction(rau_pkg::op_t op, logic [OpW-1:0] ra,
      logic [OpW-1:0] rb, logic [OpW-1:0] rc, logic [OpW-1:0] rd);
    longint a, b, c, d, num, den;
    longint unsigned g;
    fraction_t f;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    c = longint'($signed(rc));
    d = longint'($signed(rd));
    f.num = '0;
    f.den = '0;
    f.err = 1'b1;
    if (b == 0 || d == 0 || (op == rau_pkg::OP_DIV && c == 0)) return f;
    case (op)
      rau_pkg::OP_ADD: begin num = a * d + c * b; den = b * d; end
      rau_pkg::OP_SUB: begin num = a * d - c * b; den = b * d; end
      rau_pkg::OP_MUL: begin num = a * c; den = b * d; end
      default: begin num = a * d; den = c * b; end
    endcase
    if (num == 0) begin
      den = 1;
    end else begin
      g = common_divisor(mag(num), mag(den));
      num = num < 0 ? -longint'(mag(num) / g) : longint'(mag(num) / g);
      den = den < 0 ? -longint'(mag(den) / g) : longint'(mag(den) / g);
    end
    f.num = num[rau_pkg::NumWidth-1:0];
    f.den = den[rau_pkg::DenWidth-1:0];
    f.err = 1'b0;
    return f;
  endfunction

  // one request, held until accepted
  task automatic send_request(rau_pkg::op_t op, logic [OpW-1:0] a, logic [OpW-1:0] b,
      logic [OpW-1:0] c, logic [OpW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req_type <= op;
    first_numerator <= a;
    first_denominator <= b;
    second_numerator <= c;
    second_denominator <= d;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q.push_back(reduce_fraction(op, a, b, c, d));
    @(negedge clk);
  endtask

  function automatic logic [OpW-1:0] random_operand();
    case ($urandom_range(5))
      0: return OpW'($urandom_range(3)) - OpW'(1);
      1: return {1'b1, {(OpW-1){1'b0}}};
      2: return {1'b0, {(OpW-1){1'b1}}};
      3: return OpW'($signed($urandom_range(40)) - 20);
      default: return OpW'($urandom);
    endcase
  endfunction

  // result checking
  always @(posedge clk) begin
    fraction_t w;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %0d/%0d err %0b", result_numerator, result_denominator, error);
        fail_count++;
      end else begin
        w = expected_q.pop_front();
        if (result_numerator !== w.num) begin
          $error("result_numerator expected %h actual %h", w.num, result_numerator);
          fail_count++;
        end
        if (result_denominator !== w.den) begin
          $error("result_denominator expected %h actual %h", w.den, result_denominator);
          fail_count++;
        end
        if (error !== w.err) begin
          $error("error expected %b actual %b", w.err, error);
          fail_count++;
        end
      end
    end
  end

  // receiver side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  localparam logic [OpW-1:0] MaxPos = {1'b0, {(OpW-1){1'b1}}};
  localparam logic [OpW-1:0] MinNeg = {1'b1, {(OpW-1){1'b0}}};
  localparam logic [OpW-1:0] One = OpW'(1);
  localparam logic [OpW-1:0] Zero = '0;
  localparam logic [OpW-1:0] NegOne = '1;

  table_row_t directed[] = '{
    '{rau_pkg::OP_ADD, Zero, One, Zero, One, 1'b1, '{33'd0, 32'd1, 1'b0}},
    '{rau_pkg::OP_ADD, One, Zero, One, One, 1'b1, '{33'd0, 32'd0, 1'b1}},
    '{rau_pkg::OP_SUB, One, One, One, Zero, 1'b1, '{33'd0, 32'd0, 1'b1}},
    '{rau_pkg::OP_DIV, One, One, Zero, One, 1'b1, '{33'd0, 32'd0, 1'b1}},
    '{rau_pkg::OP_MUL, Zero, Zero, Zero, Zero, 1'b1, '{33'd0, 32'd0, 1'b1}},
    '{rau_pkg::OP_SUB, One, One, One, One, 1'b1, '{33'd0, 32'd1, 1'b0}},
    '{rau_pkg::OP_MUL, One, One, One, One, 1'b1, '{33'd1, 32'd1, 1'b0}},
    '{rau_pkg::OP_DIV, NegOne, One, One, One, 1'b1, '{-33'sd1, 32'd1, 1'b0}},
    '{rau_pkg::OP_ADD, MaxPos, One, MaxPos, One, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_ADD, MinNeg, One, MinNeg, One, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_SUB, MinNeg, MaxPos, MaxPos, MinNeg, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_MUL, MinNeg, One, MinNeg, One, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_MUL, MaxPos, MinNeg, MaxPos, MinNeg, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_DIV, MinNeg, MaxPos, One, MinNeg, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_DIV, MaxPos, NegOne, MinNeg, NegOne, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_ADD, One, NegOne, One, One, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_SUB, NegOne, MinNeg, MinNeg, NegOne, 1'b0, '{'0, '0, 1'b0}},
    '{rau_pkg::OP_MUL, 16'd6, 16'd4, 16'd2, 16'hfffd, 1'b0, '{'0, '0, 1'b0}}
  };

  // stimulus
  initial begin
    rau_pkg::op_t op;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) begin
      send_request(directed[i].op, directed[i].a, directed[i].b, directed[i].c, directed[i].d);
      if (directed[i].typed) expected_q[$] = directed[i].want;
    end
    for (int i = 0; i < RandomCount; i++) begin
      if (i == RandomCount / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 28;
      end else if (i == 2 * RandomCount / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold-off fills the block
      if (i == 100) hold_cycles = 2000;
      // sender pauses until everything has drained
      if (i == 300) begin
        push <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
      end
      op = rau_pkg::op_t'($urandom_range(3));
      send_request(op, random_operand(), random_operand(), random_operand(), random_operand());
    end
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
